### design/tpim_pkg.sv
// ----------------------------------------------------------------------------
// tpim_pkg: shared constants for the two-particle invariant mass block
// Default field widths and the fixed widths and limits of the result fields.
// ----------------------------------------------------------------------------
`default_nettype none

package tpim_pkg;

  localparam int MOMENTUM_BITS_DEF = 18;
  localparam int MASS_BITS_DEF     = 16;

  localparam int ENERGY_W   = 18;
  localparam int INV_MASS_W = 19;

  localparam logic [31:0] ENERGY_MAX   = 32'd262143;
  localparam logic [31:0] INV_MASS_MAX = 32'd524287;

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

`default_nettype wire

### design/tpim_pair_if.sv
// ----------------------------------------------------------------------------
// tpim_pair_if: input channel, one particle pair per beat
// Valid/ready handshake with the two momenta and rest masses.
// ----------------------------------------------------------------------------
`default_nettype none

interface tpim_pair_if
  import tpim_pkg::*;
#(
  parameter int MOMENTUM_BITS = MOMENTUM_BITS_DEF,
  parameter int MASS_BITS     = MASS_BITS_DEF
) ();
  logic                            valid;
  logic                            ready;
  logic signed [MOMENTUM_BITS-1:0] px_a;
  logic signed [MOMENTUM_BITS-1:0] py_a;
  logic signed [MOMENTUM_BITS-1:0] pz_a;
  logic        [MASS_BITS-1:0]     mass_a;
  logic signed [MOMENTUM_BITS-1:0] px_b;
  logic signed [MOMENTUM_BITS-1:0] py_b;
  logic signed [MOMENTUM_BITS-1:0] pz_b;
  logic        [MASS_BITS-1:0]     mass_b;

  modport source (
    output valid, px_a, py_a, pz_a, mass_a, px_b, py_b, pz_b, mass_b,
    input  ready
  );
  modport sink (
    input  valid, px_a, py_a, pz_a, mass_a, px_b, py_b, pz_b, mass_b,
    output ready
  );
endinterface

`default_nettype wire

### design/tpim_result_if.sv
// ----------------------------------------------------------------------------
// tpim_result_if: output channel, one result per beat
// Valid/ready handshake with both energies, the invariant mass and clamp flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface tpim_result_if
  import tpim_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [ENERGY_W-1:0]   energy_a;
  logic [ENERGY_W-1:0]   energy_b;
  logic [INV_MASS_W-1:0] inv_mass;
  logic                  clamped;

  modport source (
    output valid, energy_a, energy_b, inv_mass, clamped,
    input  ready
  );
  modport sink (
    input  valid, energy_a, energy_b, inv_mass, clamped,
    output ready
  );
endinterface

`default_nettype wire

### design/tpim_sqrt.sv
// ----------------------------------------------------------------------------
// tpim_sqrt: pipelined floor square root
// One result bit per register stage, with a sideband that travels alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module tpim_sqrt
  import tpim_pkg::*;
#(
  parameter int RAD_W  = 36,
  parameter int SIDE_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [RAD_W-1:0]  rad,
  input  wire logic [SIDE_W-1:0] side,
  output logic                   out_valid,
  output logic [RAD_W/2-1:0]     root,
  output logic [SIDE_W-1:0]      side_out
);

  localparam int ROOT_W = RAD_W / 2;

  logic              vld  [0:ROOT_W];
  logic [RAD_W-1:0]  xr   [0:ROOT_W];
  logic [ROOT_W:0]   rem  [0:ROOT_W];
  logic [ROOT_W-1:0] rt   [0:ROOT_W];
  logic [SIDE_W-1:0] sb   [0:ROOT_W];

  assign vld[0] = in_valid;
  assign xr[0]  = rad;
  assign rem[0] = '0;
  assign rt[0]  = '0;
  assign sb[0]  = side;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [ROOT_W+1:0] rem_in;
    logic [ROOT_W+1:0] trial;
    logic              ge;

    always_comb begin
      rem_in = {rem[k][ROOT_W-1:0], xr[k][RAD_W-1 -: 2]};
      trial  = {rt[k], 2'b01};
      ge     = (rem_in >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
      if (en) begin
        xr[k+1]  <= {xr[k][RAD_W-3:0], 2'b00};
        rem[k+1] <= ge ? ROOT_W'(rem_in - trial) + (ROOT_W+1)'(0) : rem_in[ROOT_W:0];
        rt[k+1]  <= {rt[k][ROOT_W-2:0], ge};
        sb[k+1]  <= sb[k];
      end
    end
  end

  assign out_valid = vld[ROOT_W];
  assign root      = rt[ROOT_W];
  assign side_out  = sb[ROOT_W];

endmodule

`default_nettype wire

### design/two_particle_invariant_mass.sv
// ----------------------------------------------------------------------------
// two_particle_invariant_mass: exact integer two-body invariant mass
// Per-particle energies and the pair's invariant mass by floor square roots.
// ----------------------------------------------------------------------------
// Usage:
//   pair   (sink)   : one beat per particle pair, signed momenta and unsigned
//                     rest masses in a common LSB unit.
//   result (source) : one beat per pair with energy_a, energy_b, inv_mass and
//                     clamped (radicand negative, inv_mass forced to zero).
// Throughput: one pair per clock; items are independent and the pipeline
//   takes a new beat every cycle while the result side keeps up.
// Pipeline: 2 front stages + EW energy root stages + 3 middle stages
//   + IW invariant root stages + 1 output register, where EW and IW are the
//   root widths (18 and 19 at default widths). Each root stage resolves one
//   result bit with one compare and subtract.
// Stall: all stages share one advance enable; when result.ready is low with
//   a beat waiting, the whole pipeline holds and pair.ready drops. No beat is
//   lost or repeated.
// Reset: rst clears all valid bits; payload registers keep whatever they hold.
// Fields that outgrow their result width at raised parameters saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module two_particle_invariant_mass
  import tpim_pkg::*;
#(
  parameter int MOMENTUM_BITS = MOMENTUM_BITS_DEF,
  parameter int MASS_BITS     = MASS_BITS_DEF
) (
  input wire logic       clk,
  input wire logic       rst,
  tpim_pair_if.sink      pair,
  tpim_result_if.source  result
);

  localparam int M       = MOMENTUM_BITS;
  localparam int SQ_W    = 2 * M;
  localparam int MSQ_W   = 2 * MASS_BITS;
  localparam int ERAD_W  = imax(2 * M - 2, MSQ_W) + 2;
  localparam int EW      = ERAD_W / 2;
  localparam int PS_W    = M + 1;
  localparam int PSQ_W   = 2 * PS_W;
  localparam int P2_W    = 2 * M + 2;
  localparam int ES_W    = EW + 1;
  localparam int E2_W    = 2 * ES_W;
  localparam int IRAD_W  = imax(P2_W, E2_W);
  localparam int IW      = IRAD_W / 2;
  localparam int ISIDE_W = 2 * EW + 1;

  // Single advance enable: move when the output slot is free or being taken.
  logic en;
  assign en         = !result.valid || result.ready;
  assign pair.ready = en;

  // Stage 1: component magnitudes and rest masses squared, pair momentum sums.
  logic [M-1:0] mag_ax, mag_ay, mag_az, mag_bx, mag_by, mag_bz;
  assign mag_ax = pair.px_a[M-1] ? M'(-pair.px_a) : M'(pair.px_a);
  assign mag_ay = pair.py_a[M-1] ? M'(-pair.py_a) : M'(pair.py_a);
  assign mag_az = pair.pz_a[M-1] ? M'(-pair.pz_a) : M'(pair.pz_a);
  assign mag_bx = pair.px_b[M-1] ? M'(-pair.px_b) : M'(pair.px_b);
  assign mag_by = pair.py_b[M-1] ? M'(-pair.py_b) : M'(pair.py_b);
  assign mag_bz = pair.pz_b[M-1] ? M'(-pair.pz_b) : M'(pair.pz_b);

  logic                   v1;
  logic [SQ_W-1:0]        sq_ax, sq_ay, sq_az, sq_bx, sq_by, sq_bz;
  logic [MSQ_W-1:0]       sq_ma, sq_mb;
  logic signed [PS_W-1:0] sum_x, sum_y, sum_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= pair.valid;
    end
    if (en) begin
      sq_ax <= SQ_W'(mag_ax) * SQ_W'(mag_ax);
      sq_ay <= SQ_W'(mag_ay) * SQ_W'(mag_ay);
      sq_az <= SQ_W'(mag_az) * SQ_W'(mag_az);
      sq_bx <= SQ_W'(mag_bx) * SQ_W'(mag_bx);
      sq_by <= SQ_W'(mag_by) * SQ_W'(mag_by);
      sq_bz <= SQ_W'(mag_bz) * SQ_W'(mag_bz);
      sq_ma <= MSQ_W'(pair.mass_a) * MSQ_W'(pair.mass_a);
      sq_mb <= MSQ_W'(pair.mass_b) * MSQ_W'(pair.mass_b);
      sum_x <= PS_W'(pair.px_a) + PS_W'(pair.px_b);
      sum_y <= PS_W'(pair.py_a) + PS_W'(pair.py_b);
      sum_z <= PS_W'(pair.pz_a) + PS_W'(pair.pz_b);
    end
  end

  // Stage 2: energy radicands, squares of the pair momentum components.
  logic [PS_W-1:0] mag_sx, mag_sy, mag_sz;
  assign mag_sx = sum_x[PS_W-1] ? PS_W'(-sum_x) : PS_W'(sum_x);
  assign mag_sy = sum_y[PS_W-1] ? PS_W'(-sum_y) : PS_W'(sum_y);
  assign mag_sz = sum_z[PS_W-1] ? PS_W'(-sum_z) : PS_W'(sum_z);

  logic               v2;
  logic [ERAD_W-1:0]  rad_a, rad_b;
  logic [PSQ_W-1:0]   psq_x, psq_y, psq_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      rad_a <= ERAD_W'(sq_ax) + ERAD_W'(sq_ay) + ERAD_W'(sq_az) + ERAD_W'(sq_ma);
      rad_b <= ERAD_W'(sq_bx) + ERAD_W'(sq_by) + ERAD_W'(sq_bz) + ERAD_W'(sq_mb);
      psq_x <= PSQ_W'(mag_sx) * PSQ_W'(mag_sx);
      psq_y <= PSQ_W'(mag_sy) * PSQ_W'(mag_sy);
      psq_z <= PSQ_W'(mag_sz) * PSQ_W'(mag_sz);
    end
  end

  // Energy roots; the momentum squares ride along as sideband.
  logic               va, vb;
  logic [EW-1:0]      ea, eb;
  logic [PSQ_W-1:0]   psq_x_d;
  logic [2*PSQ_W-1:0] psq_yz_d;

  tpim_sqrt #(.RAD_W(ERAD_W), .SIDE_W(PSQ_W)) u_sqrt_a (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v2),
    .rad      (rad_a),
    .side     (psq_x),
    .out_valid(va),
    .root     (ea),
    .side_out (psq_x_d)
  );

  tpim_sqrt #(.RAD_W(ERAD_W), .SIDE_W(2 * PSQ_W)) u_sqrt_b (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v2),
    .rad      (rad_b),
    .side     ({psq_y, psq_z}),
    .out_valid(vb),
    .root     (eb),
    .side_out (psq_yz_d)
  );

  // Stage 3: energy sum and total momentum squared.
  logic            v3;
  logic [EW-1:0]   ea3, eb3;
  logic [ES_W-1:0] esum3;
  logic [P2_W-1:0] p2_3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= va;
    end
    if (en) begin
      ea3   <= ea;
      eb3   <= eb;
      esum3 <= ES_W'(ea) + ES_W'(eb);
      p2_3  <= P2_W'(psq_x_d) + P2_W'(psq_yz_d[2*PSQ_W-1:PSQ_W])
             + P2_W'(psq_yz_d[PSQ_W-1:0]);
    end
  end

  // Stage 4: square the energy sum.
  logic            v4;
  logic [EW-1:0]   ea4, eb4;
  logic [E2_W-1:0] e2_4;
  logic [P2_W-1:0] p2_4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
    if (en) begin
      ea4  <= ea3;
      eb4  <= eb3;
      e2_4 <= E2_W'(esum3) * E2_W'(esum3);
      p2_4 <= p2_3;
    end
  end

  // Stage 5: radicand, clamp a negative one to zero.
  logic              v5;
  logic [EW-1:0]     ea5, eb5;
  logic              clamp5;
  logic [IRAD_W-1:0] irad5;
  logic              neg4;
  assign neg4 = IRAD_W'(e2_4) < IRAD_W'(p2_4);

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
    if (en) begin
      ea5    <= ea4;
      eb5    <= eb4;
      clamp5 <= neg4;
      irad5  <= neg4 ? '0 : IRAD_W'(e2_4) - IRAD_W'(p2_4);
    end
  end

  // Invariant mass root; energies and clamp flag ride along.
  logic               vi;
  logic [IW-1:0]      inv;
  logic [ISIDE_W-1:0] iside;

  tpim_sqrt #(.RAD_W(IRAD_W), .SIDE_W(ISIDE_W)) u_sqrt_inv (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v5),
    .rad      (irad5),
    .side     ({ea5, eb5, clamp5}),
    .out_valid(vi),
    .root     (inv),
    .side_out (iside)
  );

  // Output register with saturation to the result field widths.
  logic [31:0] ea_x, eb_x, inv_x;
  assign ea_x  = 32'(iside[ISIDE_W-1 -: EW]);
  assign eb_x  = 32'(iside[EW:1]);
  assign inv_x = 32'(inv);

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (en) begin
      result.valid <= vi;
    end
    if (en) begin
      result.energy_a <= (ea_x > ENERGY_MAX) ? ENERGY_MAX[ENERGY_W-1:0]
                                             : ea_x[ENERGY_W-1:0];
      result.energy_b <= (eb_x > ENERGY_MAX) ? ENERGY_MAX[ENERGY_W-1:0]
                                             : eb_x[ENERGY_W-1:0];
      result.inv_mass <= (inv_x > INV_MASS_MAX) ? INV_MASS_MAX[INV_MASS_W-1:0]
                                                : inv_x[INV_MASS_W-1:0];
      result.clamped  <= iside[0];
    end
  end

  // Both energy root lanes stay in lockstep.
  a_lanes_lockstep: assert property (@(posedge clk) disable iff (rst) va == vb)
    else $error("energy root lanes out of step");

  // A clamped result carries a zero invariant mass.
  a_clamp_zero: assert property (@(posedge clk) disable iff (rst)
      result.valid && result.clamped |-> result.inv_mass == '0)
    else $error("clamped result with nonzero mass");

  // Nothing leaves the block in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !result.valid)
    else $error("result valid right after reset");

  // A held result keeps the pipeline frozen.
  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
      result.valid && !result.ready |=> $stable(v5) && $stable(irad5))
    else $error("pipeline advanced during stall");

endmodule

`default_nettype wire
